/* rtl/assert_macros.svh */
// assertion helpers, clocked on a named clock and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/ehpd_pkg.sv */
`default_nettype none
package ehpd_pkg;

    localparam int WINDOW_BYTES = 16;
    localparam int WINDOW_W     = 8 * WINDOW_BYTES;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ADDRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_VALID_MASK = 3'd6;

    localparam logic [7:0] ENC_ALIGNED = 8'h50;

    localparam logic [3:0] FMT_ABSPTR  = 4'h0;
    localparam logic [3:0] FMT_ULEB128 = 4'h1;
    localparam logic [3:0] FMT_UDATA2  = 4'h2;
    localparam logic [3:0] FMT_UDATA4  = 4'h3;
    localparam logic [3:0] FMT_UDATA8  = 4'h4;
    localparam logic [3:0] FMT_SLEB128 = 4'h9;
    localparam logic [3:0] FMT_SDATA2  = 4'ha;
    localparam logic [3:0] FMT_SDATA4  = 4'hb;
    localparam logic [3:0] FMT_SDATA8  = 4'hc;

    localparam logic [2:0] KIND_ABS      = 3'd0;
    localparam logic [2:0] KIND_PCREL    = 3'd1;
    localparam logic [2:0] KIND_TEXTREL  = 3'd2;
    localparam logic [2:0] KIND_DATAREL  = 3'd3;
    localparam logic [2:0] KIND_FUNCREL  = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_NO_BASE    = 2'd2;
    localparam logic [1:0] ST_UNTERM     = 2'd3;

    typedef struct packed {
        logic [7:0]  encoding_byte;
        logic [31:0] position;
        logic [63:0] bytes_lo;
        logic [63:0] bytes_hi;
    } t_in;

    typedef struct packed {
        logic [63:0] pointer_value;
        logic [4:0]  consumed;
        logic [1:0]  status;
    } t_out;

endpackage
`default_nettype wire

/* rtl/eh_pointer_decoder.sv */
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+--------------------------
// command   | in        | i_start && !o_busy             | i_in  (t_in)
// result    | out       | o_valid, one cycle, no stall   | o_out (t_out)
// config    | in        | i_cfg_valid && o_cfg_ready     | i_cfg_index, i_cfg_data
//
// three register stages: decode and base select, value extraction, final add
// one transfer per cycle in, each result passes through the stage 1, 2 and 3 registers to the output
// o_busy stays low, the pipeline never stops since results cannot be held off
// synchronous active-low reset clears valid bits and resets configuration registers (wide address set)
`default_nettype none
`include "assert_macros.svh"
module eh_pointer_decoder
    import ehpd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_in                   i_in,
    output logic                       o_valid,
    output t_out                       o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic        r_big_endian;
    logic        r_wide_address;
    logic [63:0] r_section_base;
    logic [63:0] r_text_base;
    logic [63:0] r_data_base;
    logic [63:0] r_function_base;
    logic [3:0]  r_base_valid_mask;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian      <= 1'b0;
            r_wide_address    <= 1'b1;
            r_section_base    <= '0;
            r_text_base       <= '0;
            r_data_base       <= '0;
            r_function_base   <= '0;
            r_base_valid_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BIG_ENDIAN:      r_big_endian      <= i_cfg_data[0];
                CFG_WIDE_ADDRESS:    r_wide_address    <= i_cfg_data[0];
                CFG_SECTION_BASE:    r_section_base    <= i_cfg_data;
                CFG_TEXT_BASE:       r_text_base       <= i_cfg_data;
                CFG_DATA_BASE:       r_data_base       <= i_cfg_data;
                CFG_FUNCTION_BASE:   r_function_base   <= i_cfg_data;
                CFG_BASE_VALID_MASK: r_base_valid_mask <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1: decode, terminator search, alignment, base select
    logic                r_s1_valid;
    logic [WINDOW_W-1:0] r_s1_window;
    logic [3:0]          r_s1_fmt;
    logic                r_s1_aligned;
    logic                r_s1_is_leb;
    logic [2:0]          r_s1_pad;
    logic [3:0]          r_s1_nbytes;
    logic [4:0]          r_s1_leb_len;
    logic [4:0]          r_s1_consumed;
    logic [63:0]         r_s1_base;
    logic [1:0]          r_s1_status;

    logic [WINDOW_W-1:0] n_s1_window;
    logic [3:0]          n_s1_fmt;
    logic [2:0]          n_s1_kind;
    logic                n_s1_aligned;
    logic                n_s1_is_leb;
    logic                n_s1_fmt_ok;
    logic                n_s1_base_ok;
    logic [2:0]          n_s1_off;
    logic [2:0]          n_s1_pad;
    logic [3:0]          n_s1_nbytes;
    logic [4:0]          n_s1_leb_len;
    logic [4:0]          n_s1_consumed;
    logic [63:0]         n_s1_base;
    logic [1:0]          n_s1_status;

    always_comb begin
        n_s1_window  = {i_in.bytes_hi, i_in.bytes_lo};
        n_s1_fmt     = i_in.encoding_byte[3:0];
        n_s1_kind    = i_in.encoding_byte[6:4];
        n_s1_aligned = (i_in.encoding_byte == ENC_ALIGNED);
        n_s1_is_leb  = 1'b0;
        n_s1_fmt_ok  = 1'b1;
        n_s1_nbytes  = 4'd8;
        case (n_s1_fmt)
            FMT_ABSPTR:  n_s1_nbytes = r_wide_address ? 4'd8 : 4'd4;
            FMT_ULEB128: n_s1_is_leb = 1'b1;
            FMT_UDATA2:  n_s1_nbytes = 4'd2;
            FMT_UDATA4:  n_s1_nbytes = 4'd4;
            FMT_UDATA8:  n_s1_nbytes = 4'd8;
            FMT_SLEB128: n_s1_is_leb = 1'b1;
            FMT_SDATA2:  n_s1_nbytes = 4'd2;
            FMT_SDATA4:  n_s1_nbytes = 4'd4;
            FMT_SDATA8:  n_s1_nbytes = 4'd8;
            default:     n_s1_fmt_ok = 1'b0;
        endcase
        if (n_s1_aligned) begin
            n_s1_is_leb = 1'b0;
            n_s1_nbytes = r_wide_address ? 4'd8 : 4'd4;
        end

        // first byte with a clear continuation bit
        n_s1_leb_len = 5'd0;
        for (int i = WINDOW_BYTES - 1; i >= 0; i--) begin
            if (!n_s1_window[8*i+7]) begin
                n_s1_leb_len = 5'(i + 1);
            end
        end

        n_s1_off = r_section_base[2:0] + i_in.position[2:0];
        n_s1_pad = (3'd0 - n_s1_off) & (r_wide_address ? 3'd7 : 3'd3);
        if (!n_s1_aligned) begin
            n_s1_pad = 3'd0;
        end

        n_s1_base    = '0;
        n_s1_base_ok = 1'b1;
        case (n_s1_kind)
            KIND_ABS: begin
                n_s1_base = '0;
            end
            KIND_PCREL: begin
                n_s1_base    = r_section_base + {32'd0, i_in.position};
                n_s1_base_ok = r_base_valid_mask[0];
            end
            KIND_TEXTREL: begin
                n_s1_base    = r_text_base;
                n_s1_base_ok = r_base_valid_mask[1];
            end
            KIND_DATAREL: begin
                n_s1_base    = r_data_base;
                n_s1_base_ok = r_base_valid_mask[2];
            end
            KIND_FUNCREL: begin
                n_s1_base    = r_function_base;
                n_s1_base_ok = r_base_valid_mask[3];
            end
            default: begin
                n_s1_base    = '0;
                n_s1_base_ok = 1'b1;
            end
        endcase
        if (n_s1_aligned) begin
            n_s1_base = '0;
        end

        if (n_s1_is_leb) begin
            n_s1_consumed = n_s1_leb_len;
        end else begin
            n_s1_consumed = {1'b0, n_s1_nbytes} + {2'b00, n_s1_pad};
        end

        if (n_s1_aligned) begin
            n_s1_status = r_base_valid_mask[0] ? ST_OK : ST_NO_BASE;
        end else if (!n_s1_fmt_ok || n_s1_kind > KIND_FUNCREL) begin
            n_s1_status = ST_INVALID;
        end else if (n_s1_is_leb && n_s1_leb_len == 5'd0) begin
            n_s1_status = ST_UNTERM;
        end else if (!n_s1_base_ok) begin
            n_s1_status = ST_NO_BASE;
        end else begin
            n_s1_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_window   <= n_s1_window;
        r_s1_fmt      <= n_s1_fmt;
        r_s1_aligned  <= n_s1_aligned;
        r_s1_is_leb   <= n_s1_is_leb;
        r_s1_pad      <= n_s1_pad;
        r_s1_nbytes   <= n_s1_nbytes;
        r_s1_leb_len  <= n_s1_leb_len;
        r_s1_consumed <= n_s1_consumed;
        r_s1_base     <= n_s1_base;
        r_s1_status   <= n_s1_status;
    end

    // stage 2: value extraction
    logic        r_s2_valid;
    logic [63:0] r_s2_val;
    logic [63:0] r_s2_base;
    logic [4:0]  r_s2_consumed;
    logic [1:0]  r_s2_status;

    logic [WINDOW_W-1:0] n_s2_shifted;
    logic [63:0]         n_s2_rev;
    logic [63:0]         n_s2_le;
    logic [63:0]         n_s2_be;
    logic [63:0]         n_s2_fixed;
    logic [63:0]         n_s2_leb;
    logic [63:0]         n_s2_smask;
    logic                n_s2_sbit;
    logic [63:0]         n_s2_val;

    always_comb begin
        n_s2_shifted = r_s1_window >> {r_s1_pad, 3'b000};
        n_s2_le      = n_s2_shifted[63:0] & ~({64{1'b1}} << {r_s1_nbytes, 3'b000});
        for (int k = 0; k < 8; k++) begin
            n_s2_rev[8*k +: 8] = n_s2_shifted[8*(7-k) +: 8];
        end
        n_s2_be    = n_s2_rev >> {4'd8 - r_s1_nbytes, 3'b000};
        n_s2_fixed = r_big_endian ? n_s2_be : n_s2_le;

        n_s2_leb   = '0;
        n_s2_sbit  = 1'b0;
        n_s2_smask = '0;
        for (int i = 0; i < 10; i++) begin
            if (5'(i) < r_s1_leb_len) begin
                n_s2_leb = n_s2_leb | (64'(r_s1_window[8*i +: 7]) << (7 * i));
            end
        end
        for (int i = 0; i < 9; i++) begin
            if (r_s1_leb_len == 5'(i + 1)) begin
                n_s2_sbit  = r_s1_window[8*i+6];
                n_s2_smask = {64{1'b1}} << (7 * (i + 1));
            end
        end
        if (r_s1_fmt == FMT_SLEB128 && n_s2_sbit) begin
            n_s2_leb = n_s2_leb | n_s2_smask;
        end

        if (r_s1_is_leb) begin
            n_s2_val = n_s2_leb;
        end else if (!r_s1_aligned && r_s1_fmt == FMT_SDATA2) begin
            n_s2_val = {{48{n_s2_fixed[15]}}, n_s2_fixed[15:0]};
        end else if (!r_s1_aligned && r_s1_fmt == FMT_SDATA4) begin
            n_s2_val = {{32{n_s2_fixed[31]}}, n_s2_fixed[31:0]};
        end else begin
            n_s2_val = n_s2_fixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_val      <= n_s2_val;
        r_s2_base     <= r_s1_base;
        r_s2_consumed <= r_s1_consumed;
        r_s2_status   <= r_s1_status;
    end

    // stage 3: base add, truncation, error clearing
    logic        r_s3_valid;
    t_out        r_s3_out;
    logic [63:0] n_s3_ptr;
    t_out        n_s3_out;

    always_comb begin
        n_s3_ptr = r_s2_base + r_s2_val;
        if (!r_wide_address) begin
            n_s3_ptr = {32'd0, n_s3_ptr[31:0]};
        end
        n_s3_out.status = r_s2_status;
        if (r_s2_status == ST_OK) begin
            n_s3_out.pointer_value = n_s3_ptr;
            n_s3_out.consumed      = r_s2_consumed;
        end else begin
            n_s3_out.pointer_value = '0;
            n_s3_out.consumed      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_out <= n_s3_out;
    end

    assign o_valid = r_s3_valid;
    assign o_out   = r_s3_out;

    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_start && !o_busy, r_s1_valid)
    `ASSERT_NEXT(a_s2_to_out, i_clk, i_rst_n, r_s2_valid, o_valid)
    `ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_valid && o_out.status != ST_OK, o_out.pointer_value == 64'd0 && o_out.consumed == 5'd0)
    `ASSERT_IMPLIES(a_ok_consumes, i_clk, i_rst_n, o_valid && o_out.status == ST_OK, o_out.consumed != 5'd0)

endmodule
`default_nettype wire
